// File: hdl/ldc_pkg.sv
// Shared constants and command/status types for the light distance cull unit.
`timescale 1ns / 1ps
`default_nettype none
package ldc_pkg;

	// Default number of chain slots, and the largest number kept per frame
	localparam int KEEP_SLOTS_DEF = 8;
	localparam int CHAIN_MAX      = 8;

	// Field widths
	localparam int ID_W    = 8;
	localparam int DIST_W  = 24;
	localparam int LIMIT_W = 4;
	localparam int REG_W   = 24;
	localparam int REG_IDX_W = 1;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_CULL_DIST  = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEEP_LIMIT = 1'd1;

	// Register reset values
	localparam logic [DIST_W-1:0]  CULL_RESET  = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	// Controller -> datapath
	typedef struct packed {
		logic insert;   // an input beat is taken this cycle
		logic load;     // move the chain head into the output register
		logic out_valid;// loaded beat names a light
		logic out_last; // loaded beat closes the frame
		logic clear;    // return the chain to its reset contents
	} ldc_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic               out_free; // output register can take a beat
		logic [LIMIT_W-1:0] emit_n;   // number of lights to emit this frame
	} ldc_sts_t;

endpackage
`default_nettype wire

// File: hdl/ldc_chain.sv
// Datapath: config registers, sorted compare-and-shift slot chain, output register.
`timescale 1ns / 1ps
`default_nettype none
module ldc_chain
	import ldc_pkg::*;
#(
	parameter int KEEP_SLOTS = KEEP_SLOTS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [REG_IDX_W-1:0]  cfg_index,
	input  wire [REG_W-1:0]      cfg_data,
	input  wire [ID_W-1:0]       in_id,
	input  wire [DIST_W-1:0]     in_dist,
	input  wire ldc_cmd_t        cmd,
	output ldc_sts_t             sts,
	input  wire                  m_tready,
	output logic                 m_tvalid,
	output logic [ID_W-1:0]      m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);

	localparam int CAP   = (KEEP_SLOTS < CHAIN_MAX) ? KEEP_SLOTS : CHAIN_MAX;
	localparam int CNT_W = $clog2(CAP + 1);

	logic [DIST_W-1:0]  cull_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [DIST_W-1:0]  slot_d_q  [CAP];
	logic [ID_W-1:0]    slot_id_q [CAP];
	logic [CNT_W-1:0]   cnt_q;
	logic [CAP-1:0]     le;
	logic               take;
	logic [LIMIT_W-1:0] lim_sat;
	logic [LIMIT_W-1:0] cnt_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_q  <= CULL_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CULL_DIST:  cull_q  <= cfg_data[DIST_W-1:0];
				REG_KEEP_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Lights past the cull distance never enter the chain
	assign take = cmd.insert && (in_dist < cull_q);

	// Empty slots hold all ones, which no surviving distance reaches,
	// so le is a run of ones from the head up to the insert position.
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			le[i] = slot_d_q[i] <= in_dist;
		end
	end

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		logic [DIST_W-1:0] prev_d, next_d;
		logic [ID_W-1:0]   prev_id, next_id;
		logic              prev_le;

		if (i == 0) begin : g_head
			assign prev_d  = in_dist;
			assign prev_id = in_id;
			assign prev_le = 1'b1;
		end else begin : g_body
			assign prev_d  = slot_d_q[i-1];
			assign prev_id = slot_id_q[i-1];
			assign prev_le = le[i-1];
		end

		if (i == CAP - 1) begin : g_tail
			assign next_d  = '1;
			assign next_id = '0;
		end else begin : g_mid
			assign next_d  = slot_d_q[i+1];
			assign next_id = slot_id_q[i+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slot_d_q[i]  <= '1;
				slot_id_q[i] <= '0;
			end else if (cmd.clear) begin
				slot_d_q[i]  <= '1;
				slot_id_q[i] <= '0;
			end else if (cmd.load) begin
				// emission pops the head
				slot_d_q[i]  <= next_d;
				slot_id_q[i] <= next_id;
			end else if (take && !le[i]) begin
				if (prev_le) begin
					slot_d_q[i]  <= in_dist;
					slot_id_q[i] <= in_id;
				end else begin
					slot_d_q[i]  <= prev_d;
					slot_id_q[i] <= prev_id;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
		end else if (take && !le[CAP-1] && (cnt_q != CNT_W'(CAP))) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Limit of zero acts as one; above the chain size it saturates
	always_comb begin
		if (limit_q == '0) begin
			lim_sat = LIMIT_W'(1);
		end else if (limit_q > LIMIT_W'(CAP)) begin
			lim_sat = LIMIT_W'(CAP);
		end else begin
			lim_sat = limit_q;
		end
		cnt_ext = LIMIT_W'(cnt_q);
	end

	assign sts.emit_n   = (cnt_ext < lim_sat) ? cnt_ext : lim_sat;
	assign sts.out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_tdata <= cmd.out_valid ? slot_id_q[0] : '0;
			m_tuser <= cmd.out_valid;
			m_tlast <= cmd.out_last;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ldc_ctrl.sv
// Controller: accept phase and frame emission sequencing.
`timescale 1ns / 1ps
`default_nettype none
module ldc_ctrl
	import ldc_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       s_tvalid,
	input  wire       s_tlast,
	output logic      s_tready,
	input  wire ldc_sts_t sts,
	output ldc_cmd_t  cmd
);

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_EMIT   = 1'b1;

	logic               state_q;
	logic [LIMIT_W-1:0] k_q;
	logic               fin;

	assign s_tready = (state_q == ST_ACCEPT);

	// Nothing kept gives a single invalid beat that closes the frame
	assign fin = (sts.emit_n == '0) || ((k_q + LIMIT_W'(1)) == sts.emit_n);

	always_comb begin
		cmd.insert    = s_tvalid && s_tready;
		cmd.load      = (state_q == ST_EMIT) && sts.out_free;
		cmd.out_valid = (sts.emit_n != '0);
		cmd.out_last  = fin;
		cmd.clear     = cmd.load && fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_ACCEPT: begin
					if (s_tvalid && s_tlast) begin
						state_q <= ST_EMIT;
						k_q     <= '0;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (fin) begin
							state_q <= ST_ACCEPT;
						end else begin
							k_q <= k_q + LIMIT_W'(1);
						end
					end
				end
				default: state_q <= ST_ACCEPT;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/light_distance_cull_k_nearest_unit.sv
// Top level of the light distance cull unit with k-nearest selection.
// Usage:
//  - Lights stream in on the s_ group, one beat each: id and distance in
//    s_tdata, end of frame on s_tlast. A light at or beyond the cull distance
//    is dropped; the rest enter a chain of slots kept sorted by distance,
//    with ties going to the earlier light. The chain holds min(KEEP_SLOTS, 8).
//  - While a frame is arriving one beat is taken every cycle; each beat is
//    sorted into the chain in the cycle it is taken by the compare-and-shift
//    cells.
//  - After the beat with s_tlast, input stalls while the kept ids leave on
//    the m_ group, nearest first, one per cycle from the output register:
//    n = min(kept, limit) beats, or one beat with m_tuser low if none is kept.
//    The first result shows once the controller has entered its emit state
//    and the chain head has been loaded into the output register.
//  - A stalled receiver simply holds the current beat; emission resumes
//    when m_tready returns. The next frame is taken as soon as the final
//    beat sits in the output register.
//  - Reset clears the chain, sets cull distance to all ones, keep limit to 8.
//    Registers are written by the user only while the unit is idle (unchecked).
`timescale 1ns / 1ps
`default_nettype none
module light_distance_cull_k_nearest_unit
	import ldc_pkg::*;
#(
	parameter int KEEP_SLOTS = KEEP_SLOTS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	// config write port
	input  wire                     cfg_we,
	input  wire [REG_IDX_W-1:0]     cfg_index,
	input  wire [REG_W-1:0]         cfg_data,
	// light input
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire [ID_W+DIST_W-1:0]   s_tdata,  // [7:0] light_id, [31:8] light_distance
	input  wire                     s_tlast,  // last_light
	// kept light output
	output logic                    m_tvalid,
	input  wire                     m_tready,
	output logic [ID_W-1:0]         m_tdata,  // [7:0] kept_id
	output logic                    m_tuser,  // [0] kept_valid
	output logic                    m_tlast   // last_kept
);

	ldc_cmd_t cmd;
	ldc_sts_t sts;

	// Sequencer: accept phase, then one emission beat per free output slot
	ldc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Sorted slot chain, config registers and output register
	ldc_chain #(
		.KEEP_SLOTS (KEEP_SLOTS)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_id     (s_tdata[ID_W-1:0]),
		.in_dist   (s_tdata[ID_W+DIST_W-1:ID_W]),
		.cmd       (cmd),
		.sts       (sts),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// File: sim/light_distance_cull_k_nearest_unit_tb.sv
// Self-checking testbench for the light distance cull k-nearest unit.
`timescale 1ns / 1ps
module light_distance_cull_k_nearest_unit_tb;
	import ldc_pkg::*;

	localparam int RANK_CAP     = (KEEP_SLOTS_DEF < CHAIN_MAX) ? KEEP_SLOTS_DEF : CHAIN_MAX;
	localparam int SETTLE       = 8;     // idle cycles before a register write
	localparam int DRAIN_CYCLES = 20;    // quiet cycles before the verdict
	localparam int STALL_LIMIT  = 4000;  // cycles with no beat anywhere
	localparam int HOLD_OFF     = 300;   // long receiver stall

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            valid;
		logic            last;
	} kept_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [REG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	wire                   s_tready;
	logic [ID_W+DIST_W-1:0] s_tdata = '0;  // [7:0] light_id, [31:8] light_distance
	logic                  s_tlast = 1'b0; // last_light
	wire                   m_tvalid;
	logic                  m_tready = 1'b0;
	wire  [ID_W-1:0]       m_tdata;        // [7:0] kept_id
	wire                   m_tuser;        // [0] kept_valid
	wire                   m_tlast;        // last_kept

	// Predicted unit state
	logic [DIST_W-1:0]  cull_cfg;
	logic [LIMIT_W-1:0] limit_cfg;
	logic [DIST_W-1:0]  near_dist [RANK_CAP];
	logic [ID_W-1:0]    near_id [RANK_CAP];
	int                 near_count;

	kept_beat_t expected_kept_q[$];
	int mismatch_count = 0;
	int lights_sent = 0;
	bit sender_gaps_on = 1'b1;
	bit receiver_stalls_on = 1'b1;
	int hold_off_cycles = 0;

	light_distance_cull_k_nearest_unit #(
		.KEEP_SLOTS(KEEP_SLOTS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void clear_rank();
		for (int i = 0; i < RANK_CAP; i++) begin
			near_dist[i] = '1;
			near_id[i] = '0;
		end
		near_count = 0;
	endfunction

	function automatic void copy_reg_write(input logic [REG_IDX_W-1:0] idx,
			input logic [REG_W-1:0] data);
		if (idx == REG_CULL_DIST) begin
			cull_cfg = data[DIST_W-1:0];
		end else if (idx == REG_KEEP_LIMIT) begin
			limit_cfg = data[LIMIT_W-1:0];
		end
	endfunction

	// Cull, sort into the nearest-k chain, and on the frame end queue the emitted ids
	function automatic void rank_light(input logic [ID_W-1:0] id,
			input logic [DIST_W-1:0] light_dist, input logic last);
		int pos;
		int j;
		int lim;
		int n;
		kept_beat_t beat;
		if (light_dist < cull_cfg) begin
			pos = 0;
			// equal distances stay ahead: earlier arrival wins the tie
			while (pos < near_count && near_dist[pos] <= light_dist)
				pos++;
			if (pos < RANK_CAP) begin
				j = (near_count < RANK_CAP) ? near_count : RANK_CAP - 1;
				while (j > pos) begin
					near_dist[j] = near_dist[j-1];
					near_id[j] = near_id[j-1];
					j--;
				end
				near_dist[pos] = light_dist;
				near_id[pos] = id;
				if (near_count < RANK_CAP)
					near_count++;
			end
		end
		if (last) begin
			lim = (limit_cfg == '0) ? 1 : int'(limit_cfg);
			if (lim > RANK_CAP)
				lim = RANK_CAP;
			n = (near_count < lim) ? near_count : lim;
			if (n == 0) begin
				beat.id = '0;
				beat.valid = 1'b0;
				beat.last = 1'b1;
				expected_kept_q = {expected_kept_q, beat};
			end else begin
				for (int k = 0; k < n; k++) begin
					beat.id = near_id[k];
					beat.valid = 1'b1;
					beat.last = (k == n - 1);
					expected_kept_q = {expected_kept_q, beat};
				end
			end
			clear_rank();
		end
	endfunction

	// ---------------------------------------------------------------- monitor / checker

	// Inputs are sampled before the edge updates, so each beat is seen exactly once
	always @(posedge clk) begin
		kept_beat_t want;
		if (arst_n) begin
			if (cfg_we)
				copy_reg_write(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				rank_light(s_tdata[ID_W-1:0], s_tdata[ID_W+DIST_W-1:ID_W], s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_kept_q.size() == 0) begin
					$display("%0t: unexpected result beat: expected none, actual id %02h valid %0b last %0b",
						$time, m_tdata, m_tuser, m_tlast);
					mismatch_count++;
				end else begin
					want = expected_kept_q.pop_front();
					if (m_tdata !== want.id) begin
						$display("%0t: kept_id mismatch: expected %02h, actual %02h",
							$time, want.id, m_tdata);
						mismatch_count++;
					end
					if (m_tuser !== want.valid) begin
						$display("%0t: kept_valid mismatch: expected %0b, actual %0b",
							$time, want.valid, m_tuser);
						mismatch_count++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: last_kept mismatch: expected %0b, actual %0b",
							$time, want.last, m_tlast);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Watchdog: quits when nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("** light_distance_cull_k_nearest_unit: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- receiver

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// One assignment per pass, then at least one edge
	initial begin
		int hold;
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				hold = hold_off_cycles;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
				hold_off_cycles = 0;
			end else if (!receiver_stalls_on || $urandom_range(0, 99) < 65) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// Leaves s_tvalid high after the beat; the next call either reloads it or drops it
	task automatic send_light(input logic [ID_W-1:0] id, input logic [DIST_W-1:0] light_dist,
			input logic last);
		int gap;
		gap = sender_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {light_dist, id};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		lights_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_kept_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mix of wide random, near-threshold, tied, and extreme distances
	function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] tie_base);
		int r;
		logic [DIST_W-1:0] c;
		c = cull_cfg;
		r = $urandom_range(0, 99);
		if (r < 25)
			return DIST_W'($urandom);
		else if (r < 45)
			return DIST_W'(c + $urandom_range(0, 3) - 2);
		else if (r < 65)
			return DIST_W'(tie_base + $urandom_range(0, 3));
		else if (r < 72)
			return '0;
		else if (r < 78)
			return '1;
		return (c == '0) ? DIST_W'($urandom) : DIST_W'($urandom % c);
	endfunction

	task automatic send_random_frame(input int len);
		logic [DIST_W-1:0] tie_base;
		tie_base = (cull_cfg == '0) ? DIST_W'($urandom) : DIST_W'($urandom % cull_cfg);
		for (int i = 0; i < len; i++)
			send_light(ID_W'($urandom_range(0, 255)), pick_distance(tie_base), i == len - 1);
	endtask

	function automatic int pick_frame_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 10);
		else if (r < 95)
			return $urandom_range(11, 20);
		return $urandom_range(1, 2);
	endfunction

	// ---------------------------------------------------------------- tests

	// Reset settings: all-ones distance is culled, the rest kept
	task automatic test_reset_defaults();
		send_light(8'h00, 24'h000000, 1'b0);
		send_light(8'hFF, 24'hFFFFFE, 1'b0);
		send_light(8'h5A, 24'hFFFFFF, 1'b1);
	endtask

	// Frame where everything is culled yields one invalid beat
	task automatic test_nothing_kept();
		send_light(8'h33, 24'hFFFFFF, 1'b1);
	endtask

	task automatic test_tie_order();
		send_light(8'd1, 24'd100, 1'b0);
		send_light(8'd2, 24'd50, 1'b0);
		send_light(8'd3, 24'd100, 1'b0);
		send_light(8'd4, 24'd50, 1'b1);
	endtask

	// Full chain: a nearer light evicts the farthest, a farther one is dropped;
	// limit 15 saturates to the chain size
	task automatic test_chain_overflow();
		write_reg(REG_KEEP_LIMIT, REG_W'(15));
		for (int i = 0; i < 8; i++)
			send_light(ID_W'(8'h10 + i), 24'd900 - 24'(i * 100), 1'b0);
		send_light(8'h20, 24'd50, 1'b0);
		send_light(8'h21, 24'd950, 1'b1);
	endtask

	task automatic test_limit_zero();
		write_reg(REG_KEEP_LIMIT, REG_W'(0));
		send_light(8'd7, 24'd300, 1'b0);
		send_light(8'd8, 24'd200, 1'b1);
	endtask

	task automatic test_cull_zero();
		write_reg(REG_CULL_DIST, REG_W'(0));
		write_reg(REG_KEEP_LIMIT, REG_W'(8));
		send_light(8'd9, 24'd0, 1'b0);
		send_light(8'd10, 24'd0, 1'b1);
	endtask

	// Limit in force at the frame end decides the count
	task automatic test_limit_mid_frame();
		write_reg(REG_CULL_DIST, REG_W'(24'hFFFFFF));
		send_light(8'd11, 24'd5, 1'b0);
		send_light(8'd12, 24'd3, 1'b0);
		write_reg(REG_KEEP_LIMIT, REG_W'(1));
		send_light(8'd13, 24'd4, 1'b1);
	endtask

	task automatic test_random_frames();
		logic [DIST_W-1:0] cull;
		logic [LIMIT_W-1:0] lim;
		int stop_at;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin cull = '1;                  lim = 4'd8;  end
				1: begin cull = 24'd1;               lim = 4'd3;  end
				2: begin cull = DIST_W'($urandom);   lim = 4'd1;  end
				3: begin cull = 24'h800000;          lim = 4'd15; end
				4: begin cull = '0;                  lim = 4'd0;  end
				5: begin
					cull = DIST_W'($urandom_range(256, 65535));
					lim = LIMIT_W'($urandom_range(0, 15));
				end
				6: begin
					cull = DIST_W'($urandom);
					lim = LIMIT_W'($urandom_range(1, 8));
				end
				default: begin cull = 24'hFFFFFE;    lim = 4'd8;  end
			endcase
			write_reg(REG_CULL_DIST, REG_W'(cull));
			write_reg(REG_KEEP_LIMIT, REG_W'(lim));
			// some phases run with no idling on one side
			sender_gaps_on = (phase % 3 != 0);
			receiver_stalls_on = (phase % 4 != 1);
			stop_at = lights_sent + ((phase == 4) ? 15 : 55);
			while (lights_sent < stop_at)
				send_random_frame(pick_frame_len());
		end
		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	// Receiver holds off for a long stretch while lights keep coming
	task automatic test_backpressure();
		int stop_at;
		write_reg(REG_CULL_DIST, REG_W'(24'hFFFFFF));
		write_reg(REG_KEEP_LIMIT, REG_W'(8));
		sender_gaps_on = 1'b0;
		hold_off_cycles = HOLD_OFF;
		stop_at = lights_sent + 60;
		while (lights_sent < stop_at)
			send_random_frame($urandom_range(3, 12));
		sender_gaps_on = 1'b1;
	endtask

	// Sender waits for every result of a frame before starting the next
	task automatic test_drain_pause();
		int stop_at;
		write_reg(REG_CULL_DIST, REG_W'($urandom_range(4096, 24'hFFFFFF)));
		write_reg(REG_KEEP_LIMIT, REG_W'($urandom_range(1, 8)));
		stop_at = lights_sent + 40;
		while (lights_sent < stop_at) begin
			send_random_frame(pick_frame_len());
			wait_drained();
		end
	endtask

	initial begin
		cull_cfg = CULL_RESET;
		limit_cfg = LIMIT_RESET;
		clear_rank();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_nothing_kept();
		test_tie_order();
		test_chain_overflow();
		test_limit_zero();
		test_cull_zero();
		test_limit_mid_frame();
		test_random_frames();
		test_backpressure();
		test_drain_pause();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_kept_q.size() == 0)
			$display("** light_distance_cull_k_nearest_unit: PASSED **");
		else
			$display("** light_distance_cull_k_nearest_unit: FAILED **");
		$finish;
	end

endmodule
